FILE: hdl/csvt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the CSV row tokenizer.
// No dependencies; imported by every module of the block.
package csvt_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] BYTE_CR = 8'd13;
  localparam logic [7:0] BYTE_LF = 8'd10;
  localparam logic [7:0] SEP_RESET = 8'd44;
  localparam logic [7:0] QUOTE_RESET = 8'd34;

  localparam logic CFG_SEP = 1'b0;
  localparam logic CFG_QUOTE = 1'b1;

  typedef enum logic [1:0] {
    EV_CONTENT = 2'd0,
    EV_CELL_MORE = 2'd1,
    EV_ROW_END = 2'd2,
    EV_EMPTY_ROW = 2'd3
  } event_kind_t;

  // One classified byte: one event, or a row end followed by a second event.
  typedef struct packed {
    logic two;
    event_kind_t kind0;
    event_kind_t kind1;
    logic [7:0] data;
  } entry_t;

endpackage

FILE: hdl/csvt_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, parse phase and byte classification.
// Depends on csvt_pkg; pushes classified entries into csvt_fifo.
module csvt_front import csvt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       action,
  input  logic [7:0] data_byte,
  input  logic       q_full,
  output logic       push,
  output entry_t     push_entry
);

  typedef enum logic [2:0] {
    PH_ROW_START = 3'd0,
    PH_AFTER_CR = 3'd1,
    PH_CELL_START = 3'd2,
    PH_UNQUOTED = 3'd3,
    PH_QUOTED = 3'd4,
    PH_QUOTE_SEEN = 3'd5
  } phase_t;

  phase_t phase, phase_next;
  logic [7:0] separator_byte;
  logic [7:0] quote_byte;
  logic emit;
  logic accept;
  logic is_cr, is_lf, is_sep, is_quote;

  assign is_cr = (data_byte == BYTE_CR);
  assign is_lf = (data_byte == BYTE_LF);
  assign is_sep = (data_byte == separator_byte);
  assign is_quote = (data_byte == quote_byte);

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;
  assign push = accept && emit;

  always_comb begin
    phase_next = phase;
    emit = 1'b0;
    push_entry.two = 1'b0;
    push_entry.kind0 = EV_CONTENT;
    push_entry.kind1 = EV_CONTENT;
    push_entry.data = data_byte;
    if (action) begin
      emit = (phase != PH_ROW_START) && (phase != PH_AFTER_CR);
      push_entry.kind0 = EV_ROW_END;
      phase_next = PH_ROW_START;
    end else begin
      case (phase)
        PH_CELL_START: begin
          emit = 1'b1;
          if (is_cr) begin
            push_entry.kind0 = EV_ROW_END;
            phase_next = PH_AFTER_CR;
          end else if (is_lf) begin
            push_entry.kind0 = EV_ROW_END;
            phase_next = PH_ROW_START;
          end else if (is_quote) begin
            emit = 1'b0;
            phase_next = PH_QUOTED;
          end else if (is_sep) begin
            push_entry.kind0 = EV_CELL_MORE;
            phase_next = PH_CELL_START;
          end else begin
            phase_next = PH_UNQUOTED;
          end
        end
        PH_UNQUOTED: begin
          emit = 1'b1;
          if (is_sep) begin
            push_entry.kind0 = EV_CELL_MORE;
            phase_next = PH_CELL_START;
          end else if (is_cr) begin
            push_entry.kind0 = EV_ROW_END;
            phase_next = PH_AFTER_CR;
          end else if (is_lf) begin
            push_entry.kind0 = EV_ROW_END;
            phase_next = PH_ROW_START;
          end
        end
        PH_QUOTED: begin
          if (is_quote) begin
            phase_next = PH_QUOTE_SEEN;
          end else begin
            emit = 1'b1;
          end
        end
        PH_QUOTE_SEEN: begin
          emit = 1'b1;
          if (is_quote) begin
            phase_next = PH_QUOTED;
          end else if (is_sep) begin
            push_entry.kind0 = EV_CELL_MORE;
            phase_next = PH_CELL_START;
          end else if (is_cr) begin
            push_entry.kind0 = EV_ROW_END;
            phase_next = PH_AFTER_CR;
          end else if (is_lf) begin
            push_entry.kind0 = EV_ROW_END;
            phase_next = PH_ROW_START;
          end else begin
            // stray byte: close the row, then open a new one with this byte
            push_entry.two = 1'b1;
            push_entry.kind0 = EV_ROW_END;
            push_entry.kind1 = EV_CONTENT;
            phase_next = PH_UNQUOTED;
          end
        end
        default: begin
          // row start, also just after a CR (LF there is swallowed)
          emit = 1'b1;
          if (phase == PH_AFTER_CR && is_lf) begin
            emit = 1'b0;
            phase_next = PH_ROW_START;
          end else if (is_cr) begin
            push_entry.kind0 = EV_EMPTY_ROW;
            phase_next = PH_AFTER_CR;
          end else if (is_lf) begin
            push_entry.kind0 = EV_EMPTY_ROW;
            phase_next = PH_ROW_START;
          end else if (is_quote) begin
            emit = 1'b0;
            phase_next = PH_QUOTED;
          end else if (is_sep) begin
            push_entry.kind0 = EV_CELL_MORE;
            phase_next = PH_CELL_START;
          end else begin
            phase_next = PH_UNQUOTED;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_ROW_START;
      separator_byte <= SEP_RESET;
      quote_byte <= QUOTE_RESET;
    end else begin
      if (accept) begin
        phase <= phase_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SEP: separator_byte <= cfg_data;
          CFG_QUOTE: quote_byte <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: hdl/csvt_fifo.sv
`timescale 1ns / 1ps
// Short entry queue between the classifier and the event sequencer.
// Depends on csvt_pkg for the entry type and depth.
module csvt_fifo import csvt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head
);

  entry_t mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

FILE: hdl/csvt_back.sv
`timescale 1ns / 1ps
// Back end: turns queued entries into one event a word, with output register.
// Depends on csvt_pkg; pops entries from csvt_fifo.
module csvt_back import csvt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  entry_t      head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output event_kind_t event_kind,
  output logic [7:0]  content_byte,
  output logic        last_of_run
);

  logic second;
  logic load;
  event_kind_t kind_sel;

  assign load = head_valid && (!out_valid || out_ready);
  assign pop = load && (!head.two || second);
  assign kind_sel = second ? head.kind1 : head.kind0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      // hold the entry for a second word when it carries two events
      second <= head.two && !second;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      event_kind <= kind_sel;
      content_byte <= (kind_sel == EV_CONTENT) ? head.data : 8'd0;
      last_of_run <= !head.two || second;
    end
  end

  a_second_after_row_end: assert property (@(posedge clk) disable iff (rst)
    second |-> out_valid && event_kind == EV_ROW_END && !last_of_run)
    else $error("second event pending without a row end in front");
  a_second_needs_head: assert property (@(posedge clk) disable iff (rst)
    second |-> head_valid && head.two)
    else $error("second event pending but head entry lost");
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != EV_CONTENT |-> content_byte == 8'd0)
    else $error("non-content word carries a byte");

endmodule

FILE: hdl/csv_row_tokenizer.sv
`timescale 1ns / 1ps
// CSV row tokenizer: takes one byte, or an end-of-input marker, per input word
// and gives cell content bytes and cell-end, row-end and empty-row events.
// The classifier accepts one input word every cycle while the four-entry
// queue has room; the sequencer delivers one event per cycle while out_ready
// is high. A byte that closes a quoted cell and starts a new row gives two
// events; bytes that give no event (an opening or closing quote, an LF after
// CR) never reach the output. Events pass the queue and output register. The
// user must write separator and quote bytes over the configuration port (index
// 0 and 1) only while the block is idle; the block does not enforce this.
module csv_row_tokenizer import csvt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  event_kind,
  output logic [7:0]  content_byte,
  output logic        last_of_run
);

  logic q_full;
  logic push;
  entry_t push_entry;
  logic pop;
  logic head_valid;
  entry_t head;
  event_kind_t kind;

  csvt_front u_front (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .data_byte(data_byte),
    .q_full(q_full),
    .push(push),
    .push_entry(push_entry)
  );

  csvt_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_entry(push_entry),
    .full(q_full),
    .pop(pop),
    .head_valid(head_valid),
    .head(head)
  );

  csvt_back u_back (
    .clk(clk),
    .rst(rst),
    .head_valid(head_valid),
    .head(head),
    .pop(pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .event_kind(kind),
    .content_byte(content_byte),
    .last_of_run(last_of_run)
  );

  assign event_kind = kind;

endmodule

FILE: bench/tb_csv_row_tokenizer.sv
`timescale 1ns / 1ps
// Self-checking bench for csv_row_tokenizer: directed rows, register corners and random streams.
// Depends on hdl/csvt_pkg.sv and hdl/csv_row_tokenizer.sv; an internal tokenizer predicts events.
module tb_csv_row_tokenizer;
  import csvt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END = 1'b1;

  typedef enum logic [2:0] {
    ST_ROW, ST_AFTER_CR, ST_CELL, ST_PLAIN, ST_QUOTED, ST_QUOTE_SEEN
  } scan_state_t;

  typedef struct {
    event_kind_t kind;
    logic [7:0]  data;
    logic        last;
  } token_event_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic       action;
  logic [7:0] data_byte;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] event_kind;
  logic [7:0] content_byte;
  logic       last_of_run;

  // Predictor state and register copies
  scan_state_t  scan_state = ST_ROW;
  logic [7:0]   sep_cfg = SEP_RESET;
  logic [7:0]   quote_cfg = QUOTE_RESET;
  token_event_t word_events[$];
  token_event_t pending_events[$];

  int fault_count = 0;
  int words_sent = 0;
  int cycle_count = 0;
  bit source_gaps = 1'b0;
  bit sink_stalls = 1'b0;

  csv_row_tokenizer dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .action(action), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .event_kind(event_kind), .content_byte(content_byte), .last_of_run(last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic void emit(event_kind_t k, logic [7:0] b);
    token_event_t e;
    e.kind = k;
    e.data = (k == EV_CONTENT) ? b : 8'h00;
    e.last = 1'b0;
    word_events.push_back(e);
  endfunction

  // A byte arriving where a new row begins.
  function automatic void open_row(logic [7:0] b);
    if (b == BYTE_CR) begin
      emit(EV_EMPTY_ROW, 8'h00);
      scan_state = ST_AFTER_CR;
    end else if (b == BYTE_LF) begin
      emit(EV_EMPTY_ROW, 8'h00);
      scan_state = ST_ROW;
    end else if (b == quote_cfg) begin
      scan_state = ST_QUOTED;
    end else if (b == sep_cfg) begin
      emit(EV_CELL_MORE, 8'h00);
      scan_state = ST_CELL;
    end else begin
      emit(EV_CONTENT, b);
      scan_state = ST_PLAIN;
    end
  endfunction

  // Separator first, then CR and LF; returns 0 when the byte ends nothing.
  function automatic bit close_cell(logic [7:0] b);
    if (b == sep_cfg) begin
      emit(EV_CELL_MORE, 8'h00);
      scan_state = ST_CELL;
    end else if (b == BYTE_CR) begin
      emit(EV_ROW_END, 8'h00);
      scan_state = ST_AFTER_CR;
    end else if (b == BYTE_LF) begin
      emit(EV_ROW_END, 8'h00);
      scan_state = ST_ROW;
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void tokenize_word(logic act, logic [7:0] b);
    word_events.delete();
    if (act == ACT_END) begin
      if (scan_state != ST_ROW && scan_state != ST_AFTER_CR) emit(EV_ROW_END, 8'h00);
      scan_state = ST_ROW;
    end else begin
      case (scan_state)
        ST_AFTER_CR: begin
          if (b == BYTE_LF) scan_state = ST_ROW;
          else open_row(b);
        end
        ST_CELL: begin
          if (b == BYTE_CR) begin
            emit(EV_ROW_END, 8'h00);
            scan_state = ST_AFTER_CR;
          end else if (b == BYTE_LF) begin
            emit(EV_ROW_END, 8'h00);
            scan_state = ST_ROW;
          end else if (b == quote_cfg) begin
            scan_state = ST_QUOTED;
          end else if (b == sep_cfg) begin
            emit(EV_CELL_MORE, 8'h00);
          end else begin
            emit(EV_CONTENT, b);
            scan_state = ST_PLAIN;
          end
        end
        ST_PLAIN: begin
          if (!close_cell(b)) emit(EV_CONTENT, b);
        end
        ST_QUOTED: begin
          if (b == quote_cfg) scan_state = ST_QUOTE_SEEN;
          else emit(EV_CONTENT, b);
        end
        ST_QUOTE_SEEN: begin
          if (b == quote_cfg) begin
            emit(EV_CONTENT, b);
            scan_state = ST_QUOTED;
          end else if (!close_cell(b)) begin
            // stray byte: end the row, then start a fresh one with it
            emit(EV_ROW_END, 8'h00);
            open_row(b);
          end
        end
        default: open_row(b);
      endcase
    end
    if (word_events.size() > 0) word_events[word_events.size() - 1].last = 1'b1;
    foreach (word_events[i]) pending_events.push_back(word_events[i]);
  endfunction

  function automatic void report_fault(string msg);
    fault_count++;
    if (fault_count <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  // Predict on accepted input before checking output of the same edge.
  always @(posedge clk) begin : scoreboard
    token_event_t want;
    if (!rst) begin
      if (in_valid && in_ready) tokenize_word(action, data_byte);
      if (out_valid && out_ready) begin
        if (pending_events.size() == 0) begin
          report_fault($sformatf("unexpected event kind %0d byte %02h last %0d",
                                 event_kind, content_byte, last_of_run));
        end else begin
          want = pending_events.pop_front();
          if (event_kind != want.kind || content_byte != want.data ||
              last_of_run != want.last)
            report_fault($sformatf(
              "mismatch: expected kind %0d byte %02h last %0d, got kind %0d byte %02h last %0d",
              want.kind, want.data, want.last, event_kind, content_byte, last_of_run));
        end
      end
    end
  end

  initial begin : sink_pacing
    int gap;
    forever begin
      @(negedge clk);
      if (sink_stalls && $urandom_range(0, 3) == 0) begin
        gap = pick_gap();
        out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_word(logic act, logic [7:0] b);
    int gap;
    gap = (source_gaps && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
      action <= 1'($urandom_range(0, 1));
      data_byte <= 8'($urandom_range(0, 255));
    end
    @(negedge clk);
    in_valid <= 1'b1;
    action <= act;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(ACT_BYTE, s[i]);
  endtask

  // Drop valid, drain the expected events, then allow for words with no event.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SEP) sep_cfg = val;
    else quote_cfg = val;
  endtask

  task automatic apply_setting(logic [7:0] sep, logic [7:0] quote);
    wait_idle();
    write_reg(CFG_SEP, sep);
    write_reg(CFG_QUOTE, quote);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0, 1: return sep_cfg;
      2, 3: return quote_cfg;
      4: return BYTE_CR;
      5: return BYTE_LF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_cell();
    int len;
    len = $urandom_range(0, 5);
    if ($urandom_range(0, 2) == 0) begin
      send_word(ACT_BYTE, quote_cfg);
      repeat (len) begin
        case ($urandom_range(0, 5))
          0: send_word(ACT_BYTE, sep_cfg);
          1: send_word(ACT_BYTE, BYTE_CR);
          2: send_word(ACT_BYTE, BYTE_LF);
          3: begin
            send_word(ACT_BYTE, quote_cfg);
            send_word(ACT_BYTE, quote_cfg);
          end
          default: send_word(ACT_BYTE, 8'($urandom_range(0, 255)));
        endcase
      end
      send_word(ACT_BYTE, quote_cfg);
      if ($urandom_range(0, 7) == 0) send_word(ACT_BYTE, 8'($urandom_range(0, 255)));
    end else begin
      for (int i = 0; i < len; i++) begin
        if (i > 0 && $urandom_range(0, 9) == 0) send_word(ACT_BYTE, quote_cfg);
        else send_word(ACT_BYTE, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic send_row();
    int cells;
    cells = $urandom_range(0, 4);
    for (int c = 0; c < cells; c++) begin
      if (c > 0) send_word(ACT_BYTE, sep_cfg);
      send_cell();
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        send_word(ACT_BYTE, BYTE_CR);
        send_word(ACT_BYTE, BYTE_LF);
      end
      5, 6: send_word(ACT_BYTE, BYTE_LF);
      7: send_word(ACT_BYTE, BYTE_CR);
      8: send_word(ACT_END, 8'($urandom_range(0, 255)));
      default: ;
    endcase
  endtask

  // Mostly well-formed rows, with bursts of loose bytes and end markers.
  task automatic send_rows(int count);
    int start;
    start = words_sent;
    while (words_sent - start < count) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 7) == 0) send_word(ACT_END, 8'($urandom_range(0, 255)));
          else send_word(ACT_BYTE, pick_byte());
        end
      end else begin
        send_row();
      end
    end
  endtask

  task automatic test_directed_defaults();
    source_gaps = 1'b0;
    sink_stalls = 1'b0;
    send_word(ACT_END, 8'hFF);
    send_text("\015\012\012");
    send_word(ACT_BYTE, 8'h00);
    send_word(ACT_BYTE, 8'hFF);
    send_text("a\",,\015");
    send_text("\"x\"\"y\",\012");
    send_text("\"b\"z");
    send_text("\"q");
    send_word(ACT_END, 8'h00);
    wait_idle();
  endtask

  task automatic test_register_corners();
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
    apply_setting(8'h00, 8'hFF);
    send_rows(40);
    apply_setting(8'hFF, 8'h00);
    send_rows(40);
    // separator equal to quote
    apply_setting(8'h7C, 8'h7C);
    send_rows(40);
    apply_setting(BYTE_CR, BYTE_LF);
    send_rows(40);
    apply_setting(BYTE_LF, BYTE_CR);
    send_rows(40);
    apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    send_rows(40);
    apply_setting(SEP_RESET, QUOTE_RESET);
    send_rows(40);
  endtask

  task automatic test_random_stream();
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
    send_rows(450);
    // back-to-back stretch with no idling on either side
    wait_idle();
    source_gaps = 1'b0;
    sink_stalls = 1'b0;
    send_rows(150);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_SEP;
    cfg_data = 8'h00;
    in_valid = 1'b0;
    action = ACT_BYTE;
    data_byte = 8'h00;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_defaults();
    test_register_corners();
    test_random_stream();
    wait_idle();
    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
